// ----- hdl/usrs_pkg.sv -----
package usrs_pkg;

    localparam logic [2:0] CLASS_NONE  = 3'd0;
    localparam logic [2:0] CLASS_ASCII = 3'd1;
    localparam logic [2:0] CLASS_PUNCT = 3'd7;
    localparam logic [7:0] SPACE_BYTE  = 8'h20;
    localparam logic [7:0] UPPER_A     = 8'h41;
    localparam logic [7:0] UPPER_Z     = 8'h5A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       segment_start;
        logic       text_end;
    } t_result;

    // character length from the lead byte value
    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        if (b >= 8'hFC) begin
            len = 3'd6;
        end else if (b >= 8'hF8) begin
            len = 3'd5;
        end else if (b >= 8'hF0) begin
            len = 3'd4;
        end else if (b >= 8'hE0) begin
            len = 3'd3;
        end else if (b >= 8'hC0) begin
            len = 3'd2;
        end else begin
            len = 3'd1;
        end
        return len;
    endfunction

    // every byte of the punctuation text in UTF-8, taken byte by byte
    function automatic logic in_punct_set(input logic [7:0] b);
        logic hit;
        case (b) inside
            8'h20, 8'h3B, 8'h3A, 8'h2C, 8'h2E, 8'h21, 8'h3F, 8'h2D, 8'h28,
            8'h29, 8'h5C, 8'h22, 8'hE2, 8'h80, 8'hA6, 8'h9C, 8'h9D: begin
                hit = 1'b1;
            end
            default: begin
                hit = 1'b0;
            end
        endcase
        return hit;
    endfunction

endpackage

// ----- hdl/utf8_script_run_splitter_core.sv -----
// UTF-8 character-class run splitter.
// Slave stream: one text byte per beat on tdata, tlast marks the final byte
// of a text. Master stream: one kept byte per beat on tdata, tuser carries
// byte_valid (bit 0) and segment_start (bit 1), tlast marks the last beat
// of a text. A text whose last input beat yields no byte ends with a bare
// end beat (tdata 0, byte_valid 0).
// Each input beat is decoded in the cycle it is accepted and its zero, one or two
// output beats are registered in a four-entry output queue, from whose head
// the master side reads them.
// Throughput: one input beat per cycle. A beat that flushes a held space
// yields two output beats; the slave side drops tready while three or more
// queue entries are occupied, so the queue drain (one beat per cycle) sets
// the long-run rate.
// A master-side stall holds the head beat steady and backs up into the
// queue, then into the slave side. Synchronous active-low reset empties
// the queue and clears the character, run and held-space state.
module utf8_script_run_splitter_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] text_byte
    input  logic       i_s_axis_tlast,   // text_last
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic [1:0] o_m_axis_tuser,   // [0] byte_valid, [1] segment_start
    output logic       o_m_axis_tlast    // text_end
);

    localparam int QDEPTH = 4;
    localparam int PTR_W  = $clog2(QDEPTH);
    localparam int CNT_W  = $clog2(QDEPTH + 1);

    logic [2:0] r_bytes_left, n_bytes_left;
    logic [2:0] r_run_class,  n_run_class;
    logic       r_space_held, n_space_held;

    usrs_pkg::t_result r_queue [QDEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    logic              s_fire;
    logic              m_fire;
    logic [2:0]        w_len;
    logic              w_punct;
    logic [2:0]        w_cls;
    logic [7:0]        w_ob;
    usrs_pkg::t_result w_res0;
    usrs_pkg::t_result w_res1;
    logic [1:0]        w_num;

    // room for the worst case of two beats
    assign o_s_axis_tready = (r_count <= CNT_W'(QDEPTH - 2));
    assign s_fire          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = (r_count != '0);
    assign m_fire          = o_m_axis_tvalid && i_m_axis_tready;

    assign o_m_axis_tdata  = r_queue[r_rd_ptr].out_byte;
    assign o_m_axis_tuser  = {r_queue[r_rd_ptr].segment_start, r_queue[r_rd_ptr].byte_valid};
    assign o_m_axis_tlast  = r_queue[r_rd_ptr].text_end;

    assign w_len   = usrs_pkg::lead_length(i_s_axis_tdata);
    assign w_punct = usrs_pkg::in_punct_set(i_s_axis_tdata);
    assign w_cls   = w_punct ? usrs_pkg::CLASS_PUNCT : w_len;
    assign w_ob    = (w_cls == usrs_pkg::CLASS_ASCII && i_s_axis_tdata >= usrs_pkg::UPPER_A
                      && i_s_axis_tdata <= usrs_pkg::UPPER_Z)
                     ? i_s_axis_tdata + usrs_pkg::CASE_OFFSET : i_s_axis_tdata;

    always_comb begin
        n_bytes_left = r_bytes_left;
        n_run_class  = r_run_class;
        n_space_held = r_space_held;
        w_res0       = '0;
        w_res1       = '0;
        w_num        = 2'd0;
        if (s_fire) begin
            if (r_bytes_left != 3'd0) begin
                n_bytes_left = r_bytes_left - 3'd1;
                w_res0       = '{out_byte: i_s_axis_tdata, byte_valid: 1'b1,
                                 segment_start: 1'b0, text_end: 1'b0};
                w_num        = 2'd1;
            end else begin
                n_bytes_left = w_len - 3'd1;
                if (r_space_held) begin
                    n_space_held = 1'b0;
                    if (w_cls == r_run_class) begin
                        // punctuation run goes on: release the held space
                        w_res0 = '{out_byte: usrs_pkg::SPACE_BYTE, byte_valid: 1'b1,
                                   segment_start: 1'b1, text_end: 1'b0};
                        w_res1 = '{out_byte: w_ob, byte_valid: 1'b1,
                                   segment_start: 1'b0, text_end: 1'b0};
                        w_num  = 2'd2;
                    end else begin
                        n_run_class = w_cls;
                        w_res0      = '{out_byte: w_ob, byte_valid: 1'b1,
                                        segment_start: 1'b1, text_end: 1'b0};
                        w_num       = 2'd1;
                    end
                end else if (w_cls != r_run_class) begin
                    n_run_class = w_cls;
                    if (i_s_axis_tdata == usrs_pkg::SPACE_BYTE) begin
                        n_space_held = 1'b1;
                    end else begin
                        w_res0 = '{out_byte: w_ob, byte_valid: 1'b1,
                                   segment_start: 1'b1, text_end: 1'b0};
                        w_num  = 2'd1;
                    end
                end else begin
                    w_res0 = '{out_byte: w_ob, byte_valid: 1'b1,
                               segment_start: 1'b0, text_end: 1'b0};
                    w_num  = 2'd1;
                end
            end
            if (i_s_axis_tlast) begin
                case (w_num)
                    2'd0: begin
                        w_res0.text_end = 1'b1;
                        w_num           = 2'd1;
                    end
                    2'd1:    w_res0.text_end = 1'b1;
                    default: w_res1.text_end = 1'b1;
                endcase
                n_bytes_left = 3'd0;
                n_run_class  = usrs_pkg::CLASS_NONE;
                n_space_held = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left <= 3'd0;
            r_run_class  <= usrs_pkg::CLASS_NONE;
            r_space_held <= 1'b0;
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_count      <= '0;
        end else begin
            r_bytes_left <= n_bytes_left;
            r_run_class  <= n_run_class;
            r_space_held <= n_space_held;
            r_wr_ptr     <= r_wr_ptr + PTR_W'(w_num);
            r_rd_ptr     <= r_rd_ptr + PTR_W'(m_fire);
            r_count      <= r_count + CNT_W'(w_num) - CNT_W'(m_fire);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_num != 2'd0) begin
            r_queue[r_wr_ptr] <= w_res0;
        end
        if (w_num == 2'd2) begin
            r_queue[r_wr_ptr + PTR_W'(1)] <= w_res1;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QDEPTH))
        else $error("output queue overfilled");

    a_last_pushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire && i_s_axis_tlast |-> w_num != 2'd0)
        else $error("end of text produced no output beat");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire && i_s_axis_tlast |=> r_bytes_left == 3'd0
            && r_run_class == usrs_pkg::CLASS_NONE && !r_space_held)
        else $error("state not cleared after end of text");

    a_held_punct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_space_held |-> r_run_class == usrs_pkg::CLASS_PUNCT && r_bytes_left == 3'd0)
        else $error("held space outside a punctuation run");

    a_cont_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bytes_left != 3'd0 |-> r_run_class != usrs_pkg::CLASS_NONE)
        else $error("continuation pending with no open run");
`endif

endmodule
